FILE: hw/rtl/vpa_pkg.sv
// Shared types, sizes and codes of the variable partition allocator.
// No dependencies; used by the segment table, the compare unit and the top level.
package vpa_pkg;

  // Table geometry and field widths
  localparam int MAX_SEGMENTS = 16;
  localparam int SIZE_BITS    = 16;
  localparam int REQ_W        = 16;
  localparam int OWNER_W      = 8;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int UNIT_W       = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  typedef logic [SIZE_BITS-1:0] len_t;
  typedef logic [OWNER_W-1:0]   owner_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [UNIT_W-1:0]    uword_t;

  localparam len_t LEN_MAX = '1;

  // Operation codes
  localparam logic [1:0] FUNC_APPEND  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  // One segment entry
  typedef struct packed {
    owner_t owner;
    len_t   len;
  } seg_t;

  // Write request into the segment table
  typedef struct packed {
    logic en;
    idx_t idx;
    seg_t seg;
  } seg_wr_t;

  // Results of the shared compare unit
  typedef struct packed {
    logic ge;    // a >= b
    logic lt;    // a < c
    len_t diff;  // a - b, valid when ge
    len_t sum;   // a + b, saturated at LEN_MAX
  } cmp_res_t;

endpackage

FILE: hw/rtl/variable_partition_allocator_unit.sv
// Variable partition allocator: one item at a time, one table entry per cycle.
// Append writes the entry and merges, release merges, a rejected item goes right to the result.
// Allocate has a search pass, a shift pass to open a remainder slot, a merge pass and a result.
// A new item waits until the last result is loaded; a stalled result holds the sequencer.
// Reset (synchronous, rst_n low): segment count, cursor, policy and output valid clear;
// the segment table itself is not cleared.
module variable_partition_allocator_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_func,
  input  logic [vpa_pkg::OWNER_W-1:0] in_owner_id,
  input  logic [vpa_pkg::REQ_W-1:0]  in_request_size,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [vpa_pkg::IDX_W-1:0]  out_placed_index,
  output logic [vpa_pkg::CNT_W-1:0]  out_segments_in_use
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_MERGE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 policy_r;
  vpa_pkg::cnt_t              count_r, count_nxt;
  vpa_pkg::idx_t              cursor_r, cursor_nxt;
  vpa_pkg::owner_t            owner_r, owner_nxt;
  logic [vpa_pkg::REQ_W-1:0]  size_r, size_nxt;
  logic                       rel_r, rel_nxt;
  vpa_pkg::idx_t              idx_r, idx_nxt;
  vpa_pkg::cnt_t              step_r, step_nxt;
  vpa_pkg::cnt_t              wr_r, wr_nxt;
  vpa_pkg::seg_t              hold_r, hold_nxt;
  logic                       hit_r, hit_nxt;
  vpa_pkg::idx_t              hit_idx_r, hit_idx_nxt;
  vpa_pkg::len_t              hit_len_r, hit_len_nxt;
  vpa_pkg::len_t              rem_r, rem_nxt;
  vpa_pkg::cnt_t              ins_r, ins_nxt;
  logic [1:0]                 status_r, status_nxt;
  vpa_pkg::idx_t              placed_r, placed_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  vpa_pkg::idx_t              out_placed_r, out_placed_nxt;
  vpa_pkg::cnt_t              out_count_r, out_count_nxt;

  vpa_pkg::seg_wr_t  tbl_wr;
  vpa_pkg::idx_t     rd_idx;
  vpa_pkg::seg_t     rd_seg;
  vpa_pkg::uword_t   u_a, u_b, u_c;
  vpa_pkg::cmp_res_t u_res;

  logic              in_accept;
  vpa_pkg::owner_t   eff_owner;
  logic              fits;
  vpa_pkg::cnt_t     idx_inc;
  vpa_pkg::cnt_t     ins_lim;
  vpa_pkg::uword_t   req_ext;
  vpa_pkg::len_t     req_sat;
  vpa_pkg::cnt_t     ins_dec;

  vpa_seg_table u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd_idx (rd_idx),
    .rd_seg (rd_seg)
  );

  vpa_cmp_unit u_cmp (
    .a   (u_a),
    .b   (u_b),
    .c   (u_c),
    .res (u_res)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Select the table read address for the current pass
  always_comb begin
    ins_dec = ins_r - vpa_pkg::cnt_t'(1);
    case (state_r)
      S_MERGE: rd_idx = step_r[vpa_pkg::IDX_W-1:0];
      S_SHIFT: rd_idx = ins_dec[vpa_pkg::IDX_W-1:0];
      default: rd_idx = idx_r;
    endcase
  end

  // Route operands to the shared unit
  always_comb begin
    case (state_r)
      S_CHECK: begin
        u_a = vpa_pkg::UNIT_W'(hit_len_r);
        u_b = vpa_pkg::UNIT_W'(size_r);
      end
      S_MERGE: begin
        u_a = vpa_pkg::UNIT_W'(hold_r.len);
        u_b = vpa_pkg::UNIT_W'(rd_seg.len);
      end
      default: begin
        u_a = vpa_pkg::UNIT_W'(rd_seg.len);
        u_b = vpa_pkg::UNIT_W'(size_r);
      end
    endcase
    u_c = vpa_pkg::UNIT_W'(hit_len_r);
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    owner_nxt      = owner_r;
    size_nxt       = size_r;
    rel_nxt        = rel_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    wr_nxt         = wr_r;
    hold_nxt       = hold_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_len_nxt    = hit_len_r;
    rem_nxt        = rem_r;
    ins_nxt        = ins_r;
    status_nxt     = status_r;
    placed_nxt     = placed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_placed_nxt = out_placed_r;
    out_count_nxt  = out_count_r;
    tbl_wr         = '0;

    req_ext   = vpa_pkg::UNIT_W'(in_request_size);
    req_sat   = (req_ext > vpa_pkg::UNIT_W'(vpa_pkg::LEN_MAX)) ? vpa_pkg::LEN_MAX
              : req_ext[vpa_pkg::SIZE_BITS-1:0];
    eff_owner = (rel_r && rd_seg.owner == owner_r) ? '0 : rd_seg.owner;
    fits      = (rd_seg.owner == '0) && u_res.ge;
    idx_inc   = vpa_pkg::cnt_t'(idx_r) + vpa_pkg::cnt_t'(1);
    ins_lim   = vpa_pkg::cnt_t'(hit_idx_r) + vpa_pkg::cnt_t'(1);

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          owner_nxt  = in_owner_id;
          size_nxt   = in_request_size;
          rel_nxt    = 1'b0;
          placed_nxt = '0;
          step_nxt   = '0;
          wr_nxt     = '0;
          hit_nxt    = 1'b0;
          hit_len_nxt = '0;
          state_nxt  = S_DONE;
          case (in_func)
            vpa_pkg::FUNC_APPEND: begin
              if (count_r >= vpa_pkg::cnt_t'(vpa_pkg::MAX_SEGMENTS)) begin
                status_nxt = vpa_pkg::STAT_FULL;
              end else begin
                tbl_wr.en        = 1'b1;
                tbl_wr.idx       = count_r[vpa_pkg::IDX_W-1:0];
                tbl_wr.seg.owner = in_owner_id;
                tbl_wr.seg.len   = req_sat;
                count_nxt        = count_r + vpa_pkg::cnt_t'(1);
                status_nxt       = vpa_pkg::STAT_OK;
                state_nxt        = S_MERGE;
              end
            end
            vpa_pkg::FUNC_ALLOC: begin
              if (in_owner_id == '0 || in_request_size == '0) begin
                status_nxt = vpa_pkg::STAT_BAD;
              end else if (count_r == '0) begin
                status_nxt = vpa_pkg::STAT_NOFIT;
              end else begin
                idx_nxt   = (policy_r == vpa_pkg::POL_NEXT) ? cursor_r : '0;
                state_nxt = S_SEARCH;
              end
            end
            vpa_pkg::FUNC_RELEASE: begin
              if (in_owner_id == '0) begin
                status_nxt = vpa_pkg::STAT_BAD;
              end else begin
                rel_nxt    = 1'b1;
                status_nxt = vpa_pkg::STAT_OK;
                state_nxt  = S_MERGE;
              end
            end
            default: begin
              status_nxt = vpa_pkg::STAT_BAD;
            end
          endcase
        end
      end

      // Scan one entry per cycle for a fitting free hole
      S_SEARCH: begin
        step_nxt = step_r + vpa_pkg::cnt_t'(1);
        if (policy_r == vpa_pkg::POL_BEST) begin
          if (fits && (!hit_r || u_res.lt)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            hit_len_nxt = rd_seg.len;
          end
          idx_nxt = idx_inc[vpa_pkg::IDX_W-1:0];
          if (step_r == count_r - vpa_pkg::cnt_t'(1)) begin
            state_nxt = S_CHECK;
          end
        end else begin
          if (fits) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = idx_r;
            hit_len_nxt = rd_seg.len;
            state_nxt   = S_CHECK;
          end else begin
            idx_nxt = (idx_inc == count_r) ? '0 : idx_inc[vpa_pkg::IDX_W-1:0];
            if (step_r == count_r - vpa_pkg::cnt_t'(1)) begin
              state_nxt = S_CHECK;
            end
          end
        end
      end

      // Take the remainder and shrink the chosen hole, or report no fit or a full table
      S_CHECK: begin
        if (!hit_r) begin
          status_nxt = vpa_pkg::STAT_NOFIT;
          state_nxt  = S_DONE;
        end else if (u_res.diff != '0 &&
                     count_r >= vpa_pkg::cnt_t'(vpa_pkg::MAX_SEGMENTS)) begin
          status_nxt = vpa_pkg::STAT_FULL;
          state_nxt  = S_DONE;
        end else begin
          tbl_wr.en        = 1'b1;
          tbl_wr.idx       = hit_idx_r;
          tbl_wr.seg.owner = owner_r;
          tbl_wr.seg.len   = size_r[vpa_pkg::SIZE_BITS-1:0];
          placed_nxt       = hit_idx_r;
          cursor_nxt       = hit_idx_r + vpa_pkg::idx_t'(1);
          status_nxt       = vpa_pkg::STAT_OK;
          rem_nxt          = u_res.diff;
          ins_nxt          = count_r;
          step_nxt         = '0;
          wr_nxt           = '0;
          state_nxt        = (u_res.diff != '0) ? S_SHIFT : S_MERGE;
        end
      end

      // Move entries up one slot, then drop the free remainder in
      S_SHIFT: begin
        tbl_wr.en = 1'b1;
        if (ins_r > ins_lim) begin
          tbl_wr.idx = ins_r[vpa_pkg::IDX_W-1:0];
          tbl_wr.seg = rd_seg;
          ins_nxt    = ins_dec;
        end else begin
          tbl_wr.idx       = ins_lim[vpa_pkg::IDX_W-1:0];
          tbl_wr.seg.owner = '0;
          tbl_wr.seg.len   = rem_r;
          count_nxt        = count_r + vpa_pkg::cnt_t'(1);
          state_nxt        = S_MERGE;
        end
      end

      // Compact the table, freeing released owners and joining free holes
      S_MERGE: begin
        if (step_r >= count_r) begin
          count_nxt = wr_r;
          if (vpa_pkg::cnt_t'(cursor_r) >= wr_r) begin
            cursor_nxt = '0;
          end
          state_nxt = S_DONE;
        end else begin
          step_nxt  = step_r + vpa_pkg::cnt_t'(1);
          tbl_wr.en = 1'b1;
          if (eff_owner == '0 && wr_r != '0 && hold_r.owner == '0) begin
            wr_nxt           = wr_r;
            tbl_wr.idx       = wr_r[vpa_pkg::IDX_W-1:0] - vpa_pkg::idx_t'(1);
            tbl_wr.seg.owner = '0;
            tbl_wr.seg.len   = u_res.sum;
            hold_nxt.owner   = '0;
            hold_nxt.len     = u_res.sum;
          end else begin
            tbl_wr.idx       = wr_r[vpa_pkg::IDX_W-1:0];
            tbl_wr.seg.owner = eff_owner;
            tbl_wr.seg.len   = rd_seg.len;
            hold_nxt.owner   = eff_owner;
            hold_nxt.len     = rd_seg.len;
            wr_nxt           = wr_r + vpa_pkg::cnt_t'(1);
          end
        end
      end

      // Load the result register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_placed_nxt = placed_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= vpa_pkg::POL_FIRST;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        policy_r <= cfg_wr_data;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    owner_r      <= owner_nxt;
    size_r       <= size_nxt;
    rel_r        <= rel_nxt;
    idx_r        <= idx_nxt;
    step_r       <= step_nxt;
    wr_r         <= wr_nxt;
    hold_r       <= hold_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_len_r    <= hit_len_nxt;
    rem_r        <= rem_nxt;
    ins_r        <= ins_nxt;
    status_r     <= status_nxt;
    placed_r     <= placed_nxt;
    out_status_r <= out_status_nxt;
    out_placed_r <= out_placed_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_placed_index    = out_placed_r;
  assign out_segments_in_use = out_count_r;

  // Table never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= vpa_pkg::cnt_t'(vpa_pkg::MAX_SEGMENTS))
    else $error("segment count above capacity");

  // Cursor points at a valid segment or at zero between items
  a_cursor_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (cursor_r == '0 || vpa_pkg::cnt_t'(cursor_r) < count_r))
    else $error("cursor past segment count");

  // Compaction write pointer never passes the read pointer
  a_merge_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |-> wr_r <= step_r)
    else $error("merge write pointer ahead of read pointer");

  // Shifting only happens with a free slot left
  a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> count_r < vpa_pkg::cnt_t'(vpa_pkg::MAX_SEGMENTS))
    else $error("shift into full table");

  // A failed item reports a placed index of zero
  a_placed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != vpa_pkg::STAT_OK) |-> out_placed_r == '0)
    else $error("placed index on failed item");

endmodule

FILE: hw/rtl/vpa_seg_table.sv
// Segment table: register file of owner/length entries, one write and one read port.
// Depends on vpa_pkg for the entry and write request types.
module vpa_seg_table (
  input  logic             clk,
  input  vpa_pkg::seg_wr_t wr,
  input  vpa_pkg::idx_t    rd_idx,
  output vpa_pkg::seg_t    rd_seg
);

  vpa_pkg::seg_t mem_r [vpa_pkg::MAX_SEGMENTS];

  // Write one entry per cycle; contents are undefined until written
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.seg;
    end
  end

  // Read the entry addressed by the sequencer
  assign rd_seg = mem_r[rd_idx];

endmodule

FILE: hw/rtl/vpa_cmp_unit.sv
// Shared compare and arithmetic unit: fit compare, best compare, remainder, merged length.
// Depends on vpa_pkg for widths and the result struct.
module vpa_cmp_unit (
  input  vpa_pkg::uword_t  a,
  input  vpa_pkg::uword_t  b,
  input  vpa_pkg::uword_t  c,
  output vpa_pkg::cmp_res_t res
);

  logic [vpa_pkg::UNIT_W:0] sum_w;
  vpa_pkg::uword_t          diff_w;

  // Compare a against b and c, subtract and add with saturation
  always_comb begin
    sum_w     = {1'b0, a} + {1'b0, b};
    diff_w    = a - b;
    res.ge    = (a >= b);
    res.lt    = (a < c);
    res.diff  = diff_w[vpa_pkg::SIZE_BITS-1:0];
    if (sum_w > (vpa_pkg::UNIT_W + 1)'(vpa_pkg::LEN_MAX)) begin
      res.sum = vpa_pkg::LEN_MAX;
    end else begin
      res.sum = sum_w[vpa_pkg::SIZE_BITS-1:0];
    end
  end

endmodule
